// ===== sv/edfd_pkg.sv =====
// edfd_pkg: shared types and constants for the earliest-deadline-first dispatcher
// used by every dispatcher module but edfd_ram; no dependencies

package edfd_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 32;
    localparam int LEVEL_COUNT         = 10;

    localparam int ID_W     = 8;
    localparam int LEVEL_W  = 4;
    localparam int BURST_W  = 16;
    localparam int DL_W     = 16;
    localparam int STAMP_W  = 16;
    localparam int FINISH_W = 22;

    localparam int S_DATA_W = 48;   // 44 payload bits padded to bytes
    localparam int M_DATA_W = 72;   // 66 payload bits padded to bytes

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam logic STATUS_DISPATCHED = 1'b0;
    localparam logic STATUS_REJECTED   = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]    task_id;
        logic [LEVEL_W-1:0] level;
        logic [BURST_W-1:0] burst;
        logic [DL_W-1:0]    deadline;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic set;   // mark lowest free slot valid
        logic clr;   // drop the selected slot
    } slot_op_t;

    typedef struct packed {
        logic clear;    // start a new search
        logic cand_en;  // candidate on the read port is a valid entry
    } pick_ctl_t;

endpackage

// ===== sv/edfd_ram.sv =====
// edfd_ram: generic single-port-write, single-port-read ram with registered read
// depends on nothing

module edfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/edfd_slots.sv =====
// edfd_slots: valid bits, fill count and lowest-free-slot search for the task table
// depends on edfd_pkg

module edfd_slots import edfd_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  slot_op_t                         op,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   clr_idx,
    output logic [TABLE_DEPTH-1:0]           valid,
    output logic [$clog2(TABLE_DEPTH)-1:0]   free_idx,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] count
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       free_w;

    // priority encoder, lowest free slot wins
    always_comb begin
        free_w = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_w = IDX_W'(i);
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (op.set) begin
            valid_next[free_w] = 1'b1;
            count_next         = count_reg + CNT_W'(1);
        end
        if (op.clr) begin
            valid_next[clr_idx] = 1'b0;
            count_next          = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    assign valid    = valid_reg;
    assign free_idx = free_w;
    assign count    = count_reg;

`ifndef SYNTHESIS
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(count_reg))
        else $error("fill count out of step with valid bits");

    a_no_set_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        op.set |-> (int'(count_reg) < TABLE_DEPTH))
        else $error("insert into a full table");

    a_clr_only_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        op.clr |-> valid_reg[clr_idx])
        else $error("removal of an empty slot");
`endif

endmodule

// ===== sv/edfd_pick.sv =====
// edfd_pick: running best-candidate register for the deadline scan
// depends on edfd_pkg

module edfd_pick import edfd_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pick_ctl_t                      ctl,
    input  entry_t                         cand,
    input  logic [$clog2(TABLE_DEPTH)-1:0] cand_idx,
    input  logic [STAMP_W-1:0]             insert_count,
    output entry_t                         best,
    output logic [$clog2(TABLE_DEPTH)-1:0] best_idx,
    output logic                           found
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    entry_t           best_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic             found_reg, found_next;
    logic             cand_wins;
    logic [STAMP_W-1:0] age_cand, age_best;

    // age is distance from the insert counter, smaller means newer
    assign age_cand = insert_count - cand.stamp;
    assign age_best = insert_count - best_reg.stamp;

    always_comb begin
        if (cand.deadline != best_reg.deadline) begin
            cand_wins = cand.deadline < best_reg.deadline;
        end else if (cand.level != best_reg.level) begin
            cand_wins = cand.level < best_reg.level;
        end else begin
            cand_wins = age_cand < age_best;
        end
    end

    logic take;
    assign take = ctl.cand_en && !ctl.clear && (!found_reg || cand_wins);

    always_comb begin
        found_next = found_reg;
        if (ctl.clear) begin
            found_next = 1'b0;
        end else if (take) begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            best_reg     <= cand;
            best_idx_reg <= cand_idx;
        end
    end

    assign best     = best_reg;
    assign best_idx = best_idx_reg;
    assign found    = found_reg;

`ifndef SYNTHESIS
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.clear |=> !found_reg)
        else $error("search not restarted");

    a_found_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> (found_reg && best_idx_reg == $past(cand_idx)))
        else $error("candidate not captured");

    a_found_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (found_reg && !ctl.clear) |=> found_reg)
        else $error("best candidate lost mid-search");
`endif

endmodule

// ===== sv/earliest_deadline_first_dispatcher_core.sv =====
// earliest_deadline_first_dispatcher_core: top level, task table ram, scan sequencer
// and output register; depends on edfd_pkg, edfd_ram, edfd_slots, edfd_pick
//
//   channel  | ports         | tdata (low bit up)                          | tuser  | tlast
//   ---------+---------------+---------------------------------------------+--------+------
//   input    | s_tvalid/rdy  | task_id, priority_level, burst, deadline     | kind   | -
//   result   | m_tvalid/rdy  | id, level, burst, deadline, finish_time      | status | last
//
// a full table answers an add with one reject transaction
// a drain reads the table ram once per entry for each dispatched task,
// through the single ram read port
// reset clears the valid bits, fill count and insert counter; no ram clearing pass
// the input is held off while a drain runs or a result waits in the output register

module earliest_deadline_first_dispatcher_core import edfd_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // task_id, priority_level, burst_time, deadline_time
    input  logic                s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // out_task_id, out_priority_level, out_burst_time,
                                           // out_deadline_time, finish_time
    output logic                m_tuser,   // status
    output logic                m_tlast    // last
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // input fields
    logic [ID_W-1:0]    in_id;
    logic [LEVEL_W-1:0] in_level, in_level_clamped;
    logic [BURST_W-1:0] in_burst;
    logic [DL_W-1:0]    in_deadline;

    assign in_id       = s_tdata[7:0];
    assign in_level    = s_tdata[11:8];
    assign in_burst    = s_tdata[27:12];
    assign in_deadline = s_tdata[43:28];

    always_comb begin
        if (in_level == '0) begin
            in_level_clamped = LEVEL_W'(1);
        end else if ({1'b0, in_level} > (LEVEL_W + 1)'(LEVEL_COUNT)) begin
            in_level_clamped = LEVEL_W'(LEVEL_COUNT);
        end else begin
            in_level_clamped = in_level;
        end
    end

    // control registers
    logic [STAMP_W-1:0]  insert_cnt_reg, insert_cnt_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [FINISH_W-1:0] running_reg, running_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic                out_status_reg, out_last_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic [BURST_W-1:0]  out_burst_reg;
    logic [DL_W-1:0]     out_dl_reg;
    logic [FINISH_W-1:0] out_finish_reg;
    logic                out_load;
    logic                out_status_d, out_last_d;
    logic [ID_W-1:0]     out_id_d;
    logic [LEVEL_W-1:0]  out_level_d;
    logic [BURST_W-1:0]  out_burst_d;
    logic [DL_W-1:0]     out_dl_d;
    logic [FINISH_W-1:0] out_finish_d;

    // submodule links
    slot_op_t               slot_op;
    logic [TABLE_DEPTH-1:0] valid;
    logic [IDX_W-1:0]       free_idx;
    logic [CNT_W-1:0]       count;
    pick_ctl_t              pick_ctl;
    entry_t                 rd_entry, wr_entry, best;
    logic [IDX_W-1:0]       best_idx;
    logic                   found;
    logic                   ram_we;

    logic in_accept, is_add, is_drain, table_full, out_free;

    assign out_free   = !out_valid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE) && out_free;
    assign in_accept  = s_tvalid && s_tready;
    assign is_add     = in_accept && (s_tuser == KIND_ADD);
    assign is_drain   = in_accept && (s_tuser == KIND_DRAIN);
    assign table_full = (count == CNT_W'(TABLE_DEPTH));

    assign ram_we            = is_add && !table_full;
    assign wr_entry.task_id  = in_id;
    assign wr_entry.level    = in_level_clamped;
    assign wr_entry.burst    = in_burst;
    assign wr_entry.deadline = in_deadline;
    assign wr_entry.stamp    = insert_cnt_reg;

    always_comb begin
        state_next      = state_reg;
        insert_cnt_next = insert_cnt_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        running_next    = running_reg;
        slot_op         = '0;
        pick_ctl        = '0;
        out_load        = 1'b0;
        out_status_d    = STATUS_DISPATCHED;
        out_id_d        = best.task_id;
        out_level_d     = best.level;
        out_burst_d     = best.burst;
        out_dl_d        = best.deadline;
        out_finish_d    = running_reg + FINISH_W'(best.burst);
        out_last_d      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (is_add) begin
                    if (table_full) begin
                        out_load     = 1'b1;
                        out_status_d = STATUS_REJECTED;
                        out_id_d     = in_id;
                        out_level_d  = in_level_clamped;
                        out_burst_d  = in_burst;
                        out_dl_d     = in_deadline;
                        out_finish_d = '0;
                        out_last_d   = 1'b1;
                    end else begin
                        slot_op.set     = 1'b1;
                        insert_cnt_next = insert_cnt_reg + STAMP_W'(1);
                    end
                end else if (is_drain && count != '0) begin
                    running_next   = '0;
                    issue_next     = '0;
                    pick_ctl.clear = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // read issued at issue_reg, compared in the following cycle at pend_idx_reg
                if (issue_reg != CNT_W'(TABLE_DEPTH)) begin
                    issue_next    = issue_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                end
                pick_ctl.cand_en = pend_reg && valid[pend_idx_reg];
                if (issue_reg == CNT_W'(TABLE_DEPTH) && !pend_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    out_last_d   = (count == CNT_W'(1));
                    running_next = out_finish_d;
                    slot_op.clr  = 1'b1;
                    if (count == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        issue_next     = '0;
                        pick_ctl.clear = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            insert_cnt_reg <= '0;
            issue_reg      <= '0;
            pend_reg       <= 1'b0;
            running_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            insert_cnt_reg <= insert_cnt_next;
            issue_reg      <= issue_next;
            pend_reg       <= pend_next;
            running_reg    <= running_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg <= pend_idx_next;
        if (out_load) begin
            out_status_reg <= out_status_d;
            out_id_reg     <= out_id_d;
            out_level_reg  <= out_level_d;
            out_burst_reg  <= out_burst_d;
            out_dl_reg     <= out_dl_d;
            out_finish_reg <= out_finish_d;
            out_last_reg   <= out_last_d;
        end
    end

    edfd_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (free_idx),
        .wr_data (wr_entry),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    edfd_slots #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_slots (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (slot_op),
        .clr_idx  (best_idx),
        .valid    (valid),
        .free_idx (free_idx),
        .count    (count)
    );

    edfd_pick #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_pick (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (pick_ctl),
        .cand         (rd_entry),
        .cand_idx     (pend_idx_reg),
        .insert_count (insert_cnt_reg),
        .best         (best),
        .best_idx     (best_idx),
        .found        (found)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(M_DATA_W - 66)'(0), out_finish_reg, out_dl_reg, out_burst_reg,
                       out_level_reg, out_id_reg};

`ifndef SYNTHESIS
    a_emit_has_best: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> found)
        else $error("dispatch with no selected task");

    a_reject_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg == STATUS_REJECTED) |-> out_last_reg)
        else $error("reject transaction without last");

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == ST_IDLE))
        else $error("input taken during a drain");

    a_drain_ends_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && state_next == ST_IDLE) |=> (count == '0))
        else $error("drain finished with tasks left");
`endif

endmodule

// ===== tb/sv/earliest_deadline_first_dispatcher_core_tb.sv =====
`timescale 1ns / 100ps
// earliest_deadline_first_dispatcher_core_tb: self-checking bench for the edf dispatcher,
// with a queue-fed stream driver, a scoreboarding monitor and a transaction-level task table model
// depends on edfd_pkg and earliest_deadline_first_dispatcher_core

module earliest_deadline_first_dispatcher_core_tb;
    import edfd_pkg::*;

    localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
    localparam int N_RANDOM    = 450;
    localparam int HOLD_CYCLES = 600;
    localparam int IDLE_LIMIT  = 4000;
    localparam int TAIL_CYCLES = 2 * (TABLE_DEPTH + 2) + 20;

    localparam int LV_LO  = ID_W;
    localparam int BU_LO  = LV_LO + LEVEL_W;
    localparam int DL_LO  = BU_LO + BURST_W;
    localparam int FIN_LO = DL_LO + DL_W;

    typedef struct packed {
        logic               kind;
        logic [ID_W-1:0]    task_id;
        logic [LEVEL_W-1:0] level;
        logic [BURST_W-1:0] burst;
        logic [DL_W-1:0]    deadline;
    } task_item_t;

    typedef struct packed {
        logic                status;
        logic [ID_W-1:0]     task_id;
        logic [LEVEL_W-1:0]  level;
        logic [BURST_W-1:0]  burst;
        logic [DL_W-1:0]     deadline;
        logic [FINISH_W-1:0] finish;
        logic                last;
    } dispatch_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // task_id, priority_level, burst_time, deadline_time
    logic                s_tuser  = 1'b0; // kind
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // out_task_id, out_priority_level, out_burst_time,
                                          // out_deadline_time, finish_time
    logic                m_tuser;         // status
    logic                m_tlast;         // last

    earliest_deadline_first_dispatcher_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // task table model
    bit                 tbl_valid [TABLE_DEPTH];
    logic [ID_W-1:0]    tbl_id    [TABLE_DEPTH];
    logic [LEVEL_W-1:0] tbl_level [TABLE_DEPTH];
    logic [BURST_W-1:0] tbl_burst [TABLE_DEPTH];
    logic [DL_W-1:0]    tbl_dl    [TABLE_DEPTH];
    logic [STAMP_W-1:0] tbl_stamp [TABLE_DEPTH];
    logic [STAMP_W-1:0] ins_cnt = '0;

    task_item_t pend_q[$];
    dispatch_t  dispatch_q[$];
    task_item_t cur_item;

    int  n_err        = 0;
    int  n_adds       = 0;
    int  n_drains     = 0;
    int  n_dispatched = 0;
    int  n_rejected   = 0;
    int  cycle_cnt    = 0;
    int  idle_cnt     = 0;
    int  tx_gap       = 0;
    int  rx_stall     = 0;
    bit  rx_hold      = 1'b0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // true if table entry a leaves before entry b
    function automatic bit precedes(int a, int b);
        logic [STAMP_W-1:0] age_a;
        logic [STAMP_W-1:0] age_b;
        age_a = ins_cnt - tbl_stamp[a];
        age_b = ins_cnt - tbl_stamp[b];
        if (tbl_dl[a] != tbl_dl[b])
            return tbl_dl[a] < tbl_dl[b];
        if (tbl_level[a] != tbl_level[b])
            return tbl_level[a] < tbl_level[b];
        return age_a < age_b;
    endfunction

    function automatic void edf_apply(task_item_t it);
        logic [LEVEL_W-1:0]  lv;
        logic [FINISH_W-1:0] running;
        dispatch_t           d;
        int                  slot;
        int                  best;
        int                  n_left;
        lv = it.level;
        if (lv < 1)
            lv = LEVEL_W'(1);
        if (lv > LEVEL_COUNT)
            lv = LEVEL_W'(LEVEL_COUNT);
        if (it.kind == KIND_ADD) begin
            slot = -1;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (!tbl_valid[i] && slot < 0)
                    slot = i;
            if (slot < 0) begin
                d.status   = STATUS_REJECTED;
                d.task_id  = it.task_id;
                d.level    = lv;
                d.burst    = it.burst;
                d.deadline = it.deadline;
                d.finish   = '0;
                d.last     = 1'b1;
                dispatch_q.push_back(d);
            end else begin
                tbl_valid[slot] = 1'b1;
                tbl_id[slot]    = it.task_id;
                tbl_level[slot] = lv;
                tbl_burst[slot] = it.burst;
                tbl_dl[slot]    = it.deadline;
                tbl_stamp[slot] = ins_cnt;
                ins_cnt         = ins_cnt + 1'b1;
            end
        end else begin
            running = '0;
            n_left  = 0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (tbl_valid[i])
                    n_left++;
            for (int k = 0; k < n_left; k++) begin
                best = -1;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (tbl_valid[i] && (best < 0 || precedes(i, best)))
                        best = i;
                running    = running + tbl_burst[best];
                d.status   = STATUS_DISPATCHED;
                d.task_id  = tbl_id[best];
                d.level    = tbl_level[best];
                d.burst    = tbl_burst[best];
                d.deadline = tbl_dl[best];
                d.finish   = running;
                d.last     = (k == n_left - 1);
                dispatch_q.push_back(d);
                tbl_valid[best] = 1'b0;
            end
        end
    endfunction

    // one stretch in every four of the run goes without idling on either side
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((cycle_cnt / 2000) % 4 == 1 || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic task_item_t rand_add(bit tie_heavy);
        task_item_t it;
        it.kind     = KIND_ADD;
        it.task_id  = ID_W'($urandom_range(0, 255));
        it.level    = tie_heavy ? LEVEL_W'($urandom_range(1, 3)) :
                                  LEVEL_W'($urandom_range(0, 15));
        it.burst    = $urandom_range(0, 1) ? BURST_W'($urandom_range(0, 65535)) :
                                             BURST_W'($urandom_range(0, 15));
        it.deadline = tie_heavy ? DL_W'($urandom_range(0, 7)) :
                                  DL_W'($urandom_range(0, 65535));
        return it;
    endfunction

    // drains carry random payload, which the block must ignore
    function automatic task_item_t rand_drain();
        task_item_t it;
        it          = rand_add(1'b0);
        it.kind     = KIND_DRAIN;
        it.deadline = DL_W'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic task_item_t mk_item(logic kind, int id, int lv, int bu, int dl);
        task_item_t it;
        it.kind     = kind;
        it.task_id  = ID_W'(id);
        it.level    = LEVEL_W'(lv);
        it.burst    = BURST_W'(bu);
        it.deadline = DL_W'(dl);
        return it;
    endfunction

    task automatic offer_next();
        cur_item = pend_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= cur_item.kind;
        s_tdata  <= S_DATA_W'({cur_item.deadline, cur_item.burst, cur_item.level,
                               cur_item.task_id});
    endtask

    task automatic cmp_field(input string fname, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, fname, exp_v, act_v);
            n_err++;
        end
    endtask

    // input driver
    always @(posedge aclk) begin
        int gap;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                edf_apply(cur_item);
                if (cur_item.kind == KIND_ADD)
                    n_adds++;
                else
                    n_drains++;
                gap = draw_gap();
                if (gap == 0 && pend_q.size() > 0) begin
                    offer_next();
                end else begin
                    s_tvalid <= 1'b0;
                    tx_gap   <= gap;
                end
            end else if (!s_tvalid) begin
                if (tx_gap > 0)
                    tx_gap <= tx_gap - 1;
                else if (pend_q.size() > 0)
                    offer_next();
            end
        end
    end

    // result monitor and ready generation
    always @(posedge aclk) begin
        dispatch_t d;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (dispatch_q.size() == 0) begin
                    $display("%0t ns: unexpected result transaction, expected none, actual %0h",
                             $time, m_tdata);
                    n_err++;
                end else begin
                    d = dispatch_q.pop_front();
                    cmp_field("status", 32'(d.status), 32'(m_tuser));
                    cmp_field("task_id", 32'(d.task_id), 32'(m_tdata[0 +: ID_W]));
                    cmp_field("priority_level", 32'(d.level),
                              32'(m_tdata[LV_LO +: LEVEL_W]));
                    cmp_field("burst_time", 32'(d.burst), 32'(m_tdata[BU_LO +: BURST_W]));
                    cmp_field("deadline_time", 32'(d.deadline),
                              32'(m_tdata[DL_LO +: DL_W]));
                    cmp_field("finish_time", 32'(d.finish),
                              32'(m_tdata[FIN_LO +: FINISH_W]));
                    cmp_field("last", 32'(d.last), 32'(m_tlast));
                    if (d.status == STATUS_REJECTED)
                        n_rejected++;
                    else
                        n_dispatched++;
                end
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                m_tready <= 1'b0;
                rx_stall <= rx_stall - 1;
            end else begin
                m_tready <= 1'b1;
                rx_stall <= draw_gap();
            end
        end
    end

    // long receiver hold-off once traffic is flowing, so the output register stays full and input stalls
    initial begin
        while (n_dispatched < 40)
            @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int r;
        int n_add;
        int n_built;
        bit tie_heavy;
        bit first;

        // drain of an empty table, then level clamping and field extremes
        pend_q.push_back(mk_item(KIND_DRAIN, 0, 0, 0, 0));
        pend_q.push_back(mk_item(KIND_ADD, 8'h00, 0, 16'h0000, 16'hFFFF));
        pend_q.push_back(mk_item(KIND_ADD, 8'hFF, 15, 16'hFFFF, 16'h0000));
        // deadline ties: same level after clamping, newest wins; lower level wins first
        pend_q.push_back(mk_item(KIND_ADD, 8'h01, 11, 16'h0001, 16'd100));
        pend_q.push_back(mk_item(KIND_ADD, 8'h02, 10, 16'h0002, 16'd100));
        pend_q.push_back(mk_item(KIND_ADD, 8'h03, 3, 16'h0003, 16'd100));
        pend_q.push_back(mk_item(KIND_ADD, 8'h04, 3, 16'h0004, 16'd100));
        pend_q.push_back(mk_item(KIND_ADD, 8'h05, 1, 16'hFFFF, 16'hFFFF));
        pend_q.push_back(mk_item(KIND_DRAIN, 8'hFF, 15, 16'hFFFF, 16'hFFFF));
        pend_q.push_back(mk_item(KIND_DRAIN, 8'h00, 0, 16'h0000, 16'h0000));
        pend_q.push_back(mk_item(KIND_ADD, 8'hAA, 5, 16'h5555, 16'hAAAA));
        pend_q.push_back(mk_item(KIND_ADD, 8'h55, 10, 16'hAAAA, 16'h5555));
        pend_q.push_back(mk_item(KIND_ADD, 8'h80, 1, 16'h8000, 16'h5555));
        pend_q.push_back(mk_item(KIND_DRAIN, 8'h5A, 9, 16'h1234, 16'h8765));

        // the first sequence overfills the table to hit the reject path
        n_built = 0;
        first   = 1'b1;
        while (n_built < N_RANDOM) begin
            r = $urandom_range(0, 99);
            if (first || r < 70) begin
                if (first)
                    n_add = $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 4);
                else if ($urandom_range(0, 99) < 15)
                    n_add = $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 8);
                else
                    n_add = $urandom_range(1, 12);
                tie_heavy = 1'($urandom_range(0, 1));
                repeat (n_add) pend_q.push_back(rand_add(tie_heavy));
                pend_q.push_back(rand_drain());
                n_built += n_add + 1;
            end else if (r < 85) begin
                n_add = $urandom_range(1, 4);
                repeat (n_add) begin
                    if ($urandom_range(0, 1))
                        pend_q.push_back(rand_drain());
                    else
                        pend_q.push_back(rand_add(1'($urandom_range(0, 1))));
                end
                n_built += n_add;
            end else begin
                // adds left in the table for the next sequence
                n_add = $urandom_range(1, 5);
                repeat (n_add) pend_q.push_back(rand_add(1'b0));
                n_built += n_add;
            end
            first = 1'b0;
        end
        pend_q.push_back(rand_drain());

        while (pend_q.size() > 0 || s_tvalid)
            @(posedge aclk);
        while (dispatch_q.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run covered %0d adds and %0d drains, with a long result hold-off",
                 n_adds, n_drains);
        $display("%0d tasks dispatched in deadline order, %0d adds rejected on a full table",
                 n_dispatched, n_rejected);
        if (n_err == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
